// ===== design/vwsp_pkg.sv =====
// Package for the vertex weighted shortest paths block: constants, command type, helpers.
package vwsp_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int WEIGHT_BITS_DEF  = 12;
  localparam int DIST_BITS        = 16;
  localparam int CMD_VBITS        = 7;
  localparam logic [DIST_BITS-1:0] NO_EDGE  = 16'd9999;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 16'hFFFF;

  localparam logic [1:0] FUNC_WVERT = 2'd0;
  localparam logic [1:0] FUNC_WEDGE = 2'd1;
  localparam logic [1:0] FUNC_RUN   = 2'd2;

  localparam logic [1:0] CFG_VCOUNT = 2'd0;
  localparam logic [1:0] CFG_SOURCE = 2'd1;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WVERT,
    CMD_WEDGE,
    CMD_INIT,
    CMD_RELAX
  } cmd_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_RELAX,
    ST_EMIT
  } state_e;

  typedef struct packed {
    cmd_op_e                op;
    logic [CMD_VBITS-1:0]   a;
    logic [CMD_VBITS-1:0]   b;
    logic [DIST_BITS-1:0]   val;
    logic [CMD_VBITS-1:0]   n;
    logic                   src_ok;
  } cmd_t;

  function automatic logic [DIST_BITS-1:0] sat_add(input logic [DIST_BITS-1:0] x,
                                                   input logic [DIST_BITS-1:0] y);
    logic [DIST_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[DIST_BITS] ? DIST_MAX : s[DIST_BITS-1:0];
  endfunction

endpackage

// ===== design/vwsp_cell.sv =====
// One vertex cell: its matrix row, weight, distance, visited flag and a minimum-scan stage.
module vwsp_cell #(
  parameter int ID          = 1,
  parameter int MAXV        = vwsp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS = vwsp_pkg::WEIGHT_BITS_DEF,
  parameter int VW          = $clog2(MAXV + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vwsp_pkg::cmd_t                 cmd_i,
  input  logic [vwsp_pkg::DIST_BITS-1:0] best_i,
  input  logic [VW-1:0]                  pick_i,
  output logic [vwsp_pkg::DIST_BITS-1:0] best_o,
  output logic [VW-1:0]                  pick_o,
  output logic [vwsp_pkg::DIST_BITS-1:0] dist_o,
  output logic [WEIGHT_BITS-1:0]         weight_o
);

  localparam int IW      = $clog2(MAXV);
  localparam int NE_BITS = $clog2(int'(vwsp_pkg::NO_EDGE) + 1);
  localparam int EW      = (WEIGHT_BITS > NE_BITS) ? WEIGHT_BITS : NE_BITS;
  localparam logic [VW-1:0] MY = VW'(ID);

  logic [EW-1:0]                  ew_q   [MAXV];
  logic [WEIGHT_BITS-1:0]         w_q;
  logic [vwsp_pkg::DIST_BITS-1:0] d_q, d_d;
  logic                           vis_q, vis_d;
  logic [vwsp_pkg::DIST_BITS-1:0] best_q;
  logic [VW-1:0]                  pick_q;

  logic [VW-1:0]                  a, b, n, col, cm1;
  logic [IW-1:0]                  ci;
  logic [vwsp_pkg::DIST_BITS-1:0] e_col, c_val;
  logic                           row_we;
  logic [IW-1:0]                  row_ci;
  logic [VW-1:0]                  row_c;

  assign a   = cmd_i.a[VW-1:0];
  assign b   = cmd_i.b[VW-1:0];
  assign n   = cmd_i.n[VW-1:0];
  assign col = a;
  assign cm1 = col - VW'(1);
  assign ci  = cm1[IW-1:0];

  always_comb begin
    if (col == MY) begin
      e_col = '0;
    end else if (col != '0) begin
      e_col = vwsp_pkg::DIST_BITS'(ew_q[ci]);
    end else begin
      e_col = vwsp_pkg::NO_EDGE;
    end
  end

  always_comb begin
    row_we = 1'b0;
    row_c  = b;
    if (cmd_i.op == vwsp_pkg::CMD_WEDGE) begin
      if (a == MY) begin
        row_we = 1'b1;
        row_c  = b;
      end else if (b == MY) begin
        row_we = 1'b1;
        row_c  = a;
      end
    end
  end
  assign row_ci = IW'(row_c - VW'(1));

  always_comb begin
    d_d   = d_q;
    vis_d = vis_q;
    c_val = vwsp_pkg::sat_add(vwsp_pkg::sat_add(cmd_i.val, e_col),
                              vwsp_pkg::DIST_BITS'(w_q));
    case (cmd_i.op)
      vwsp_pkg::CMD_INIT: begin
        vis_d = cmd_i.src_ok && (a == MY);
        if (!cmd_i.src_ok) begin
          d_d = vwsp_pkg::DIST_MAX;
        end else if (a == MY) begin
          d_d = '0;
        end else begin
          d_d = vwsp_pkg::sat_add(vwsp_pkg::sat_add(e_col, vwsp_pkg::DIST_BITS'(w_q)),
                                  cmd_i.val);
        end
      end
      vwsp_pkg::CMD_RELAX: begin
        if (a == MY) begin
          vis_d = 1'b1;
        end else if (!vis_q && c_val < d_q) begin
          d_d = c_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAXV; j++) ew_q[j] <= EW'(vwsp_pkg::NO_EDGE);
    end else if (row_we) begin
      ew_q[row_ci] <= EW'(cmd_i.val[WEIGHT_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vwsp_pkg::CMD_WVERT && a == MY) w_q <= cmd_i.val[WEIGHT_BITS-1:0];
    d_q   <= d_d;
    vis_q <= vis_d;
    if (MY <= n && !vis_q && d_q < best_i) begin
      best_q <= d_q;
      pick_q <= MY;
    end else begin
      best_q <= best_i;
      pick_q <= pick_i;
    end
  end

  assign best_o   = best_q;
  assign pick_o   = pick_q;
  assign dist_o   = d_q;
  assign weight_o = w_q;

endmodule

// ===== design/vertex_weighted_shortest_paths.sv =====
// Top level: controller and chain of vertex cells for vertex weighted shortest paths.
//
//  channel   ports                                           handshake
//  command   func_i first_vertex_i second_vertex_i weight_i  start_i && !busy_o
//  result    vertex_o path_distance_o last_o                 result_valid_o, one cycle
//  config    cfg_idx_i cfg_data_i                            cfg_we_i
//
// Loads are taken while idle and leave busy_o low. A run initializes the distances from
// the source, then repeats a selection: a scan lets the minimum ripple down the cell
// chain, then a relax step uses it; results stream out one per cycle at the end.
// Reset loads the no-edge value into every matrix entry at once; no clearing pass.
// Results cannot be stalled; busy_o stays high until the last one.
module vertex_weighted_shortest_paths #(
  parameter int MAX_VERTICES = vwsp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = vwsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [5:0]  first_vertex_i,
  input  logic [5:0]  second_vertex_i,
  input  logic [11:0] weight_i,
  output logic        result_valid_o,
  output logic [5:0]  vertex_o,
  output logic [15:0] path_distance_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [5:0]  cfg_data_i
);

  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CV = vwsp_pkg::CMD_VBITS;
  localparam int DB = vwsp_pkg::DIST_BITS;

  logic [5:0] vcount_q, src_q;
  vwsp_pkg::state_e state_q, state_d;
  logic [VW-1:0] cnt_q, cnt_d, iter_q, iter_d, eidx_q, eidx_d;
  vwsp_pkg::cmd_t cmd;

  logic [DB-1:0]          best_w [MAX_VERTICES+1];
  logic [VW-1:0]          pick_w [MAX_VERTICES+1];
  logic [DB-1:0]          dist_w [MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] wt_w   [MAX_VERTICES];

  logic [CV-1:0] vc7, n7, s7, a7, b7;
  logic [VW-1:0] n;
  logic          src_ok, accept, a_ok, b_ok;
  logic [15:0]   wx;
  logic [DB-1:0] wval, wsrc;
  logic [VW-1:0] pick_last;

  assign vc7    = CV'(vcount_q);
  assign n7     = (vc7 > CV'(MAX_VERTICES)) ? CV'(MAX_VERTICES) : vc7;
  assign n      = n7[VW-1:0];
  assign s7     = CV'(src_q);
  assign src_ok = (s7 != '0) && (s7 <= n7);
  assign a7     = CV'(first_vertex_i);
  assign b7     = CV'(second_vertex_i);
  assign a_ok   = (a7 != '0) && (a7 <= CV'(MAX_VERTICES));
  assign b_ok   = (b7 != '0) && (b7 <= CV'(MAX_VERTICES));
  assign accept = start_i && (state_q == vwsp_pkg::ST_IDLE);
  assign wx     = 16'(weight_i);
  assign wval   = DB'(wx[WEIGHT_BITS-1:0]);
  assign wsrc   = DB'(wt_w[IW'(s7[VW-1:0] - VW'(1))]);
  assign pick_last = pick_w[MAX_VERTICES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 6'd1;
      src_q    <= 6'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == vwsp_pkg::CFG_VCOUNT) vcount_q <= cfg_data_i;
      if (cfg_idx_i == vwsp_pkg::CFG_SOURCE) src_q <= cfg_data_i;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    iter_d  = iter_q;
    eidx_d  = eidx_q;
    case (state_q)
      vwsp_pkg::ST_IDLE: begin
        if (accept && func_i == vwsp_pkg::FUNC_RUN && n != '0) state_d = vwsp_pkg::ST_INIT;
      end
      vwsp_pkg::ST_INIT: begin
        cnt_d  = '0;
        iter_d = VW'(2);
        eidx_d = VW'(1);
        if (!src_ok || n == VW'(1)) state_d = vwsp_pkg::ST_EMIT;
        else state_d = vwsp_pkg::ST_SCAN;
      end
      vwsp_pkg::ST_SCAN: begin
        cnt_d = cnt_q + VW'(1);
        if (cnt_q == VW'(MAX_VERTICES - 1)) state_d = vwsp_pkg::ST_RELAX;
      end
      vwsp_pkg::ST_RELAX: begin
        cnt_d = '0;
        if (pick_last == '0 || iter_q == n) begin
          state_d = vwsp_pkg::ST_EMIT;
        end else begin
          iter_d  = iter_q + VW'(1);
          state_d = vwsp_pkg::ST_SCAN;
        end
      end
      vwsp_pkg::ST_EMIT: begin
        eidx_d = eidx_q + VW'(1);
        if (eidx_q == n) state_d = vwsp_pkg::ST_IDLE;
      end
      default: state_d = vwsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.op     = vwsp_pkg::CMD_NONE;
    cmd.n      = n7;
    cmd.src_ok = src_ok;
    case (state_q)
      vwsp_pkg::ST_IDLE: begin
        cmd.a   = a7;
        cmd.b   = b7;
        cmd.val = wval;
        if (accept && func_i == vwsp_pkg::FUNC_WVERT && a_ok) cmd.op = vwsp_pkg::CMD_WVERT;
        if (accept && func_i == vwsp_pkg::FUNC_WEDGE && a_ok && b_ok && a7 != b7) begin
          cmd.op = vwsp_pkg::CMD_WEDGE;
        end
      end
      vwsp_pkg::ST_INIT: begin
        cmd.op  = vwsp_pkg::CMD_INIT;
        cmd.a   = s7;
        cmd.val = wsrc;
      end
      vwsp_pkg::ST_RELAX: begin
        cmd.a   = CV'(pick_last);
        cmd.val = best_w[MAX_VERTICES];
        if (pick_last != '0) cmd.op = vwsp_pkg::CMD_RELAX;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vwsp_pkg::ST_IDLE;
      cnt_q   <= '0;
      iter_q  <= '0;
      eidx_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iter_q  <= iter_d;
      eidx_q  <= eidx_d;
    end
  end

  assign best_w[0] = vwsp_pkg::NO_EDGE;
  assign pick_w[0] = '0;

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    vwsp_cell #(
      .ID          (g + 1),
      .MAXV        (MAX_VERTICES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .VW          (VW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .best_i   (best_w[g]),
      .pick_i   (pick_w[g]),
      .best_o   (best_w[g+1]),
      .pick_o   (pick_w[g+1]),
      .dist_o   (dist_w[g]),
      .weight_o (wt_w[g])
    );
  end

  assign busy_o          = (state_q != vwsp_pkg::ST_IDLE);
  assign result_valid_o  = (state_q == vwsp_pkg::ST_EMIT);
  assign vertex_o        = 6'(eidx_q);
  assign path_distance_o = dist_w[IW'(eidx_q - VW'(1))];
  assign last_o          = result_valid_o && (eidx_q == n);

endmodule

// ===== design/vwsp_chk.sv =====
// Port-level checker for the shortest paths block, bound to the top level.
module vwsp_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       busy_o,
  input logic       result_valid_o,
  input logic [5:0] vertex_o,
  input logic       last_o
);

  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result outside a run");

  a_last_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o) else $error("last without result");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |=> (result_valid_o && vertex_o == $past(vertex_o) + 6'd1))
    else $error("result stream broken");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !busy_o) else $error("busy after last transfer");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !$past(result_valid_o)) |-> vertex_o == 6'd1)
    else $error("stream does not start at vertex one");

endmodule

bind vertex_weighted_shortest_paths vwsp_chk u_vwsp_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .vertex_o       (vertex_o),
  .last_o         (last_o)
);
